/* hw/rtl/smoothed_zscore_peak_detector_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed z-score peak detector
// Each check comes in an implication form and a next-cycle form. With
// ASSERT_OFF defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_ZSCORE_PEAK_DETECTOR_ASSERT_SVH
`define SMOOTHED_ZSCORE_PEAK_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define SZP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SZP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SZP_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SZP_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/szp_pkg.sv */
// ----------------------------------------------------------------------------
// Smoothed z-score peak detector package
// Widths, register codes, reset values and shared types of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package szp_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 8;
   localparam int VAL_W       = SAMPLE_BITS + FRAC_BITS;
   localparam int ADDR_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W       = VAL_W + ADDR_W;
   localparam int SQ_W        = 2 * VAL_W + ADDR_W;
   localparam int VAR_W       = 2 * SUM_W;
   localparam int THR_W       = 12;
   localparam int INF_FRAC    = 16;
   localparam int INF_W       = INF_FRAC + 1;
   localparam int ACC_W       = VAR_W + 2 * THR_W;
   localparam int MUL_W       = SUM_W;
   localparam int STEP_W      = $clog2(MUL_W + 1);

   localparam int CFG_LEN_W   = 7;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INFLUENCE     = 2'd2;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(896);
   localparam logic [INF_W-1:0] INF_RESET = INF_W'(0);
   localparam logic [INF_W-1:0] INF_ONE   = INF_W'(1 << INF_FRAC);

   localparam logic signed [1:0] SIG_NONE = 2'sd0;
   localparam logic signed [1:0] SIG_UP   = 2'sd1;
   localparam logic signed [1:0] SIG_DOWN = -2'sd1;

   typedef struct packed {
      logic              start;
      logic              subtract;
      logic [STEP_W-1:0] steps;
   } mac_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WARM,
      ST_LY,
      ST_SQD,
      ST_LQ,
      ST_SS,
      ST_VT1,
      ST_VT2,
      ST_CMP,
      ST_FILT,
      ST_UPD,
      ST_COMMIT
   } state_type;

endpackage

/* hw/rtl/szp_req_if.sv */
// ----------------------------------------------------------------------------
// Sample channel
// Carries one raw converter sample per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface szp_req_if;
   import szp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/szp_rsp_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Carries the peak signal and the warm-up flag, one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface szp_rsp_if;
   import szp_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [1:0] signal;
   logic              warmed_up;

   modport source (output valid, output signal, output warmed_up, input ready);
   modport sink (input valid, input signal, input warmed_up, output ready);
endinterface

/* hw/rtl/szp_store.sv */
// ----------------------------------------------------------------------------
// Window store
// Ring of filtered values with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module szp_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [szp_pkg::ADDR_W-1:0] wr_addr,
   input  logic [szp_pkg::VAL_W-1:0]  wr_data,
   input  logic [szp_pkg::ADDR_W-1:0] rd_addr,
   output logic [szp_pkg::VAL_W-1:0]  rd_data
);
   import szp_pkg::*;

   logic [VAL_W-1:0] store_ff [MAX_WINDOW];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/szp_mac.sv */
// ----------------------------------------------------------------------------
// Shift-add multiply-accumulate unit
// Adds or subtracts one partial product per cycle: the multiplicand moves
// left and the multiplier right until the programmed number of steps is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "smoothed_zscore_peak_detector_assert.svh"

module szp_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  szp_pkg::mac_cmd_type      cmd,
   input  logic [szp_pkg::ACC_W-1:0] op_a,
   input  logic [szp_pkg::MUL_W-1:0] op_b,
   input  logic [szp_pkg::ACC_W-1:0] acc_init,
   output logic                      done,
   output logic [szp_pkg::ACC_W-1:0] acc
);
   import szp_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              sub_ff, sub_in;
   logic [ACC_W-1:0]  a_ff, a_in;
   logic [MUL_W-1:0]  b_ff, b_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  step_sum;

   always_comb begin
      step_sum = sub_ff ? (acc_ff - a_ff) : (acc_ff + a_ff);
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      sub_in   = sub_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         sub_in  = cmd.subtract;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = acc_init;
      end else if (busy_ff) begin
         busy_in = (cnt_ff != STEP_W'(1));
         cnt_in  = cnt_ff - STEP_W'(1);
         a_in    = a_ff << 1;
         b_in    = b_ff >> 1;
         if (b_ff[0]) begin
            acc_in = step_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sub_ff <= sub_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = busy_ff && (cnt_ff == STEP_W'(1));
   assign acc  = acc_ff;

   `SZP_ASSERT_IMP(a_start_idle, clock, reset, cmd.start, !busy_ff, "MAC started while busy")
   `SZP_ASSERT_NXT(a_start_busy, clock, reset, cmd.start, busy_ff, "MAC did not go busy")
   `SZP_ASSERT_IMP(a_busy_count, clock, reset, busy_ff, cnt_ff != '0, "MAC busy with no steps")

endmodule

/* hw/rtl/smoothed_zscore_peak_detector.sv */
// ----------------------------------------------------------------------------
// Smoothed z-score peak detector
// Takes one 12-bit sample per transfer and returns one result per sample:
// signal is +1 or -1 when the sample lies further from the mean of the
// filtered window than threshold times its standard deviation, else 0. The
// test is exact in the squared domain. All products run through one
// shift-add unit that handles one multiplier bit per cycle, so the sample
// port stays closed while an item is in progress. A warm-up sample needs
// one product, the square of the 20-bit sample value. A tested sample
// needs products with multiplier widths 7, 26, 7, 26, 12 and 12, then 17
// when it is a peak and has to be damped, then 20 for the update. A
// finished result is held in an output register, and the next sample is
// taken while it waits. Writing window_length restarts the window;
// configuration must be written only while no sample is in progress,
// and the block itself does not enforce it.
`timescale 1ns / 1ps

`include "smoothed_zscore_peak_detector_assert.svh"

module smoothed_zscore_peak_detector (
   input  logic                            clock,
   input  logic                            reset,
   szp_req_if.sink                         req_if,
   szp_rsp_if.source                       rsp_if,
   input  logic                            csr_write_en,
   input  logic [szp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [szp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import szp_pkg::*;

   state_type          state_ff, state_in;
   logic               go_ff, go_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [INF_W-1:0]   inf_ff, inf_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [VAL_W-1:0]   last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [VAL_W-1:0]   y_ff, y_in;
   logic [VAL_W-1:0]   filt_ff, filt_in;
   logic               warm_ff, warm_in;
   logic               peak_ff, peak_in;
   logic               above_ff, above_in;
   logic [VAR_W-1:0]   lhs_ff, lhs_in;
   logic signed [1:0]  rsp_signal_ff, rsp_signal_in;
   logic               rsp_warmed_ff, rsp_warmed_in;

   mac_cmd_type        mac_cmd;
   logic [ACC_W-1:0]   mac_a;
   logic [MUL_W-1:0]   mac_b;
   logic [ACC_W-1:0]   mac_acc0;
   logic               mac_done;
   logic [ACC_W-1:0]   mac_acc;

   logic [VAL_W-1:0]   old_val;
   logic               req_fire;
   logic               slot_free;
   logic               store_we;
   logic [VAL_W-1:0]   y_val;
   logic [SUM_W-1:0]   prod_low;
   logic [SUM_W-1:0]   dist_c;
   logic               peak_c;
   logic [VAL_W-1:0]   fdiff;
   logic [VAL_W-1:0]   filt_c;
   logic [VAL_W:0]     upd_sum;
   logic [VAL_W-1:0]   upd_diff;
   logic [CFG_LEN_W-1:0] len_raw;
   logic [LEN_W-1:0]   len_clamp;
   logic [INF_W-1:0]   inf_raw;
   logic [SUM_W-1:0]   old_term;

   szp_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mac_cmd),
      .op_a     (mac_a),
      .op_b     (mac_b),
      .acc_init (mac_acc0),
      .done     (mac_done),
      .acc      (mac_acc)
   );

   szp_store u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wp_ff),
      .wr_data (filt_ff),
      .rd_addr (wp_ff),
      .rd_data (old_val)
   );

   assign req_fire  = req_if.valid && req_if.ready;
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign y_val     = {req_if.sample, {FRAC_BITS{1'b0}}};

   always_comb begin
      prod_low = mac_acc[SUM_W-1:0];
      dist_c   = (prod_low >= sum_ff) ? (prod_low - sum_ff) : (sum_ff - prod_low);
      peak_c   = {{(ACC_W - VAR_W - INF_FRAC){1'b0}}, lhs_ff, {INF_FRAC{1'b0}}} > mac_acc;
      fdiff    = (y_ff >= last_ff) ? (y_ff - last_ff) : (last_ff - y_ff);
      filt_c   = peak_ff ? mac_acc[INF_FRAC +: VAL_W] : y_ff;
      upd_sum  = {1'b0, filt_c} + {1'b0, old_val};
      upd_diff = (filt_c >= old_val) ? (filt_c - old_val) : (old_val - filt_c);
      len_raw  = csr_write_data[CFG_LEN_W-1:0];
      inf_raw  = csr_write_data[INF_W-1:0];
      if (len_raw < CFG_LEN_W'(2)) begin
         len_clamp = LEN_W'(2);
      end else if (int'(len_raw) > MAX_WINDOW) begin
         len_clamp = LEN_W'(MAX_WINDOW);
      end else begin
         len_clamp = LEN_W'(len_raw);
      end
      old_term = warm_ff ? '0 : SUM_W'(old_val);
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (fill_ff < len_ff) ? ST_WARM : ST_LY;
            end
         end
         ST_WARM: if (mac_done) state_in = ST_COMMIT;
         ST_LY:   if (mac_done) state_in = ST_SQD;
         ST_SQD:  if (mac_done) state_in = ST_LQ;
         ST_LQ:   if (mac_done) state_in = ST_SS;
         ST_SS:   if (mac_done) state_in = ST_VT1;
         ST_VT1:  if (mac_done) state_in = ST_VT2;
         ST_VT2:  if (mac_done) state_in = ST_CMP;
         ST_CMP: begin
            state_in = peak_c ? ST_FILT : ST_UPD;
         end
         ST_FILT: if (mac_done) state_in = ST_UPD;
         ST_UPD:  if (mac_done) state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      go_in = (state_in != state_ff);
   end

   // Outputs of the sequencer: sample port and operands of the shared unit.
   always_comb begin
      req_if.ready     = 1'b0;
      store_we         = 1'b0;
      mac_cmd.start    = 1'b0;
      mac_cmd.subtract = 1'b0;
      mac_cmd.steps    = '0;
      mac_a            = '0;
      mac_b            = '0;
      mac_acc0         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_WARM: begin
            mac_cmd.start = go_ff;
            mac_cmd.steps = STEP_W'(VAL_W);
            mac_a         = ACC_W'(y_ff);
            mac_b         = MUL_W'(y_ff);
            mac_acc0      = ACC_W'(sq_ff);
         end
         ST_LY: begin
            mac_cmd.start = go_ff;
            mac_cmd.steps = STEP_W'(LEN_W);
            mac_a         = ACC_W'(y_ff);
            mac_b         = MUL_W'(len_ff);
         end
         ST_SQD: begin
            mac_cmd.start = go_ff;
            mac_cmd.steps = STEP_W'(SUM_W);
            mac_a         = ACC_W'(dist_c);
            mac_b         = MUL_W'(dist_c);
         end
         ST_LQ: begin
            mac_cmd.start = go_ff;
            mac_cmd.steps = STEP_W'(LEN_W);
            mac_a         = ACC_W'(sq_ff);
            mac_b         = MUL_W'(len_ff);
         end
         ST_SS: begin
            mac_cmd.start    = go_ff;
            mac_cmd.subtract = 1'b1;
            mac_cmd.steps    = STEP_W'(SUM_W);
            mac_a            = ACC_W'(sum_ff);
            mac_b            = MUL_W'(sum_ff);
            mac_acc0         = mac_acc;
         end
         ST_VT1, ST_VT2: begin
            mac_cmd.start = go_ff;
            mac_cmd.steps = STEP_W'(THR_W);
            mac_a         = mac_acc;
            mac_b         = MUL_W'(thr_ff);
         end
         ST_FILT: begin
            mac_cmd.start    = go_ff;
            mac_cmd.subtract = (y_ff < last_ff);
            mac_cmd.steps    = STEP_W'(INF_W);
            mac_a            = ACC_W'(fdiff);
            mac_b            = MUL_W'(inf_ff);
            mac_acc0         = ACC_W'({last_ff, 1'b1, {(INF_FRAC - 1){1'b0}}});
         end
         ST_UPD: begin
            mac_cmd.start    = go_ff;
            mac_cmd.subtract = (filt_c < old_val);
            mac_cmd.steps    = STEP_W'(VAL_W);
            mac_a            = ACC_W'(upd_sum);
            mac_b            = MUL_W'(upd_diff);
            mac_acc0         = ACC_W'(sq_ff);
         end
         ST_COMMIT: begin
            store_we = slot_free;
         end
         default: ;
      endcase
   end

   // Datapath and window state updates.
   always_comb begin
      len_in        = len_ff;
      thr_in        = thr_ff;
      inf_in        = inf_ff;
      wp_in         = wp_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      sq_in         = sq_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff;
      y_in          = y_ff;
      filt_in       = filt_ff;
      warm_in       = warm_ff;
      peak_in       = peak_ff;
      above_in      = above_ff;
      lhs_in        = lhs_ff;
      rsp_signal_in = rsp_signal_ff;
      rsp_warmed_in = rsp_warmed_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               len_in  = len_clamp;
               wp_in   = '0;
               fill_in = '0;
               sum_in  = '0;
               sq_in   = '0;
               last_in = '0;
            end
            CSR_THRESHOLD: thr_in = csr_write_data[THR_W-1:0];
            CSR_INFLUENCE: inf_in = (inf_raw > INF_ONE) ? INF_ONE : inf_raw;
            default: ;
         endcase
      end

      if (req_fire) begin
         y_in    = y_val;
         filt_in = y_val;
         warm_in = (fill_ff < len_ff);
         peak_in = 1'b0;
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SQD: begin
            if (go_ff) begin
               above_in = (prod_low > sum_ff);
            end
         end
         ST_LQ: begin
            if (go_ff) begin
               lhs_in = mac_acc[VAR_W-1:0];
            end
         end
         ST_CMP: begin
            peak_in = peak_c;
         end
         ST_UPD: begin
            if (go_ff) begin
               filt_in = filt_c;
            end
         end
         ST_COMMIT: begin
            if (slot_free) begin
               sq_in   = mac_acc[SQ_W-1:0];
               sum_in  = sum_ff - old_term + SUM_W'(filt_ff);
               last_in = filt_ff;
               if ((LEN_W'(wp_ff) + LEN_W'(1)) == len_ff) begin
                  wp_in = '0;
               end else begin
                  wp_in = wp_ff + ADDR_W'(1);
               end
               if (warm_ff) begin
                  fill_in = fill_ff + LEN_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_warmed_in = (fill_in >= len_ff);
               if (peak_ff) begin
                  rsp_signal_in = above_ff ? SIG_UP : SIG_DOWN;
               end else begin
                  rsp_signal_in = SIG_NONE;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         len_ff       <= LEN_RESET;
         thr_ff       <= THR_RESET;
         inf_ff       <= INF_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         len_ff       <= len_in;
         thr_ff       <= thr_in;
         inf_ff       <= inf_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff          <= y_in;
      filt_ff       <= filt_in;
      warm_ff       <= warm_in;
      peak_ff       <= peak_in;
      above_ff      <= above_in;
      lhs_ff        <= lhs_in;
      rsp_signal_ff <= rsp_signal_in;
      rsp_warmed_ff <= rsp_warmed_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.signal    = rsp_signal_ff;
   assign rsp_if.warmed_up = rsp_warmed_ff;

   `SZP_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= len_ff, "Fill count above window length")
   `SZP_ASSERT_IMP(a_wp_bound, clock, reset, 1'b1, LEN_W'(wp_ff) < len_ff, "Write position outside the ring")
   `SZP_ASSERT_NXT(a_commit_hold, clock, reset, (state_ff == ST_COMMIT) && !slot_free, state_ff == ST_COMMIT, "Result dropped while output busy")
   `SZP_ASSERT_IMP(a_peak_tested, clock, reset, peak_ff && (state_ff != ST_IDLE), !warm_ff, "Peak flagged during warm-up")

endmodule
